// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
// Holds the mode and status codes and the controller-to-datapath command struct.
// No dependencies.
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REVERSE    = 3'd4,
        MODE_PEEK       = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic step;   // apply the accepted word to the queue state
        logic load;   // capture the result into the output register
    } ctrl_cmd_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
// Sequencer for the double-ended queue core: accept, fetch, present.
// Depends on deq_pkg for the command struct.
module deq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output deq_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // Take a new word only when the output register is free by the time it loads.
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign cmd.step = s_tvalid && s_tready;
    assign cmd.load = (state_reg == S_FETCH);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd.step) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next    = S_IDLE;
                m_tvalid_next = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_step_then_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> (cmd.load && !s_tready))
        else $error("fetch did not follow an accepted word");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (!m_tvalid_reg || m_tready))
        else $error("word accepted while output register stays occupied");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
        else $error("result word dropped before it was taken");
`endif

endmodule

// ===== rtl/deq_datapath.sv =====
// Ring-buffer datapath: head pointer, count, direction flag, entry memory, result register.
// Depends on deq_pkg for mode, status and command types.
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  deq_pkg::ctrl_cmd_t              cmd,
    input  deq_pkg::mode_t                  mode,
    input  logic [deq_pkg::VALUE_W-1:0]     push_value,
    output deq_pkg::status_t                status,
    output logic [deq_pkg::VALUE_W-1:0]     front_value,
    output logic [deq_pkg::VALUE_W-1:0]     back_value,
    output logic                            is_empty,
    output logic [deq_pkg::COUNT_W-1:0]     entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          rev_reg, rev_next;
    deq_pkg::status_t status_reg, status_next;

    logic [DATA_WIDTH-1:0] wdata, wdata_reg;
    logic [DATA_WIDTH-1:0] rd_lo_reg, rd_hi_reg;
    logic                  byp_lo_reg, byp_hi_reg;
    logic                  we;
    logic [AW-1:0]         waddr;

    logic [AW-1:0] head_inc, head_dec, slot_end, lo_addr, hi_addr;
    logic [AW:0]   end_sum, hi_sum;
    logic          full, empty, front_end;

    logic [DATA_WIDTH-1:0] lo_val, hi_val, fv, bv;

    assign wdata    = DATA_WIDTH'(push_value);
    assign full     = (occ_reg == DEPTH_C);
    assign empty    = (occ_reg == '0);
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign end_sum  = {1'b0, head_reg} + (AW + 1)'(occ_reg);
    assign slot_end = (end_sum >= DEPTH_S) ? AW'(end_sum - DEPTH_S) : end_sum[AW-1:0];

    always_comb begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        rev_next    = rev_reg;
        status_next = deq_pkg::ST_OK;
        we          = 1'b0;
        waddr       = slot_end;
        front_end   = 1'b0;
        case (mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
                front_end = (mode == deq_pkg::MODE_PUSH_FRONT);
                if (full) begin
                    status_next = deq_pkg::ST_FULL;
                end else begin
                    we       = 1'b1;
                    occ_next = occ_reg + 1'b1;
                    // Logical front sits at the low end unless reversed.
                    if (front_end != rev_reg) begin
                        head_next = head_dec;
                        waddr     = head_dec;
                    end
                end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
                front_end = (mode == deq_pkg::MODE_POP_FRONT);
                if (empty) begin
                    status_next = deq_pkg::ST_EMPTY;
                end else begin
                    occ_next = occ_reg - 1'b1;
                    if (front_end != rev_reg) begin
                        head_next = head_inc;
                    end
                end
            end
            deq_pkg::MODE_REVERSE: begin
                if (empty) begin
                    status_next = deq_pkg::ST_EMPTY;
                end else begin
                    rev_next = !rev_reg;
                end
            end
            deq_pkg::MODE_PEEK: begin
                if (empty) begin
                    status_next = deq_pkg::ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    // Read both ends of the run as it stands after this word.
    assign lo_addr = head_next;
    assign hi_sum  = {1'b0, head_next} + (AW + 1)'(AW'(occ_next - 1'b1));
    assign hi_addr = (hi_sum >= DEPTH_S) ? AW'(hi_sum - DEPTH_S) : hi_sum[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            occ_reg  <= '0;
            rev_reg  <= 1'b0;
        end else if (cmd.step) begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            rev_reg  <= rev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
            rd_lo_reg  <= mem[lo_addr];
            rd_hi_reg  <= mem[hi_addr];
            // Forward the word being written when a read hits the same slot.
            byp_lo_reg <= we && (waddr == lo_addr);
            byp_hi_reg <= we && (waddr == hi_addr);
            wdata_reg  <= wdata;
            status_reg <= status_next;
        end
    end

    assign lo_val = byp_lo_reg ? wdata_reg : rd_lo_reg;
    assign hi_val = byp_hi_reg ? wdata_reg : rd_hi_reg;
    assign fv     = (occ_reg == '0) ? '0 : (rev_reg ? hi_val : lo_val);
    assign bv     = (occ_reg == '0) ? '0 : (rev_reg ? lo_val : hi_val);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status      <= status_reg;
            front_value <= deq_pkg::VALUE_W'(fv);
            back_value  <= deq_pkg::VALUE_W'(bv);
            is_empty    <= (occ_reg == '0);
            entry_count <= deq_pkg::COUNT_W'(occ_reg);
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= DEPTH_C)
        else $error("occupancy above depth");

    a_full_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status_next == deq_pkg::ST_FULL)
        |=> ($stable(occ_reg) && $stable(head_reg) && $stable(rev_reg)))
        else $error("state changed on push into full queue");

    a_empty_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status_next == deq_pkg::ST_EMPTY)
        |=> ($stable(occ_reg) && $stable(head_reg) && $stable(rev_reg)))
        else $error("state changed on operation against empty queue");
`endif

endmodule

// ===== rtl/double_ended_queue_with_reverse_core.sv =====
// Top level of the bounded double-ended queue with constant-time reverse.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//   channel | direction | tuser          | tdata
//   s_      | in        | [2:0] mode     | [31:0] push_value
//   m_      | out       | [1:0] status   | [31:0] front, [63:32] back, [64] empty, [69:65] count
//
// Each word is handled in the IDLE state, which updates pointers and writes the entry
// memory while both ends are read, then in FETCH, which moves the registered read data into the output.
// The next word is accepted while a result still waits, as long as it is taken by then.
// Synchronous active-low reset empties the queue; memory contents are not cleared.
module double_ended_queue_with_reverse_core #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] front_value, [63:32] back_value,
                                   // [64] is_empty, [69:65] entry_count, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    deq_pkg::ctrl_cmd_t cmd;
    deq_pkg::status_t   status;
    logic [deq_pkg::VALUE_W-1:0] front_value, back_value;
    logic                        is_empty;
    logic [deq_pkg::COUNT_W-1:0] entry_count;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .mode        (deq_pkg::mode_t'(s_tuser)),
        .push_value  (s_tdata),
        .status      (status),
        .front_value (front_value),
        .back_value  (back_value),
        .is_empty    (is_empty),
        .entry_count (entry_count)
    );

    assign m_tdata = {2'b00, entry_count, is_empty, back_value, front_value};
    assign m_tuser = status;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for double_ended_queue_with_reverse_core.
// Drives mode/value words and compares each result word with a behavioral deque model or a scripted view.
// Depends on deq_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH       = deq_pkg::DEPTH_DEF;
    localparam int RANDOM_WORDS = 1450;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    // unassigned mode codes, ignored by the core
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        deq_pkg::status_t status;
        logic [31:0] front;
        logic [31:0] back;
        logic        empty;
        logic [4:0]  count;
    } deq_view_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [31:0] value;
        logic [4:0] reps;
        logic       typed;
        deq_view_t  want;
    } script_row_t;

    localparam deq_view_t EMPTY_ERR = '{deq_pkg::ST_EMPTY, 32'h0, 32'h0, 1'b1, 5'd0};
    localparam deq_view_t EMPTY_OK  = '{deq_pkg::ST_OK, 32'h0, 32'h0, 1'b1, 5'd0};
    localparam deq_view_t ONE_ONES  = '{deq_pkg::ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        1'b0, 5'd1};
    localparam deq_view_t NO_VIEW   = '{deq_pkg::ST_OK, 32'h0, 32'h0, 1'b0, 5'd0};

    // rows with typed set carry their result; the rest go through the model
    localparam int SCRIPT_LEN = 20;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{deq_pkg::MODE_PEEK,       32'h0000_0000, 5'd1,  1'b1, EMPTY_ERR},
        '{deq_pkg::MODE_POP_FRONT,  32'hFFFF_FFFF, 5'd1,  1'b1, EMPTY_ERR},
        '{deq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, EMPTY_ERR},
        '{deq_pkg::MODE_REVERSE,    32'h0000_0000, 5'd1,  1'b1, EMPTY_ERR},
        '{MODE_SPARE6,              32'hFFFF_FFFF, 5'd1,  1'b1, EMPTY_OK},
        '{deq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b1, ONE_ONES},
        '{deq_pkg::MODE_REVERSE,    32'h0000_0000, 5'd1,  1'b1, ONE_ONES},
        '{deq_pkg::MODE_PUSH_BACK,  32'h0000_0000, 5'd1,  1'b1,
            '{deq_pkg::ST_OK, 32'hFFFF_FFFF, 32'h0, 1'b0, 5'd2}},
        '{deq_pkg::MODE_PEEK,       32'h1357_9BDF, 5'd1,  1'b1,
            '{deq_pkg::ST_OK, 32'hFFFF_FFFF, 32'h0, 1'b0, 5'd2}},
        '{deq_pkg::MODE_REVERSE,    32'h0000_0000, 5'd1,  1'b1,
            '{deq_pkg::ST_OK, 32'h0, 32'hFFFF_FFFF, 1'b0, 5'd2}},
        '{deq_pkg::MODE_PUSH_FRONT, 32'h8000_0001, 5'd1,  1'b0, NO_VIEW},
        '{deq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, NO_VIEW},
        '{deq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, NO_VIEW},
        '{MODE_SPARE7,              32'h1234_5678, 5'd1,  1'b0, NO_VIEW},
        '{deq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, EMPTY_OK},
        '{deq_pkg::MODE_PUSH_BACK,  32'hA5A5_0000, 5'd16, 1'b0, NO_VIEW},
        '{deq_pkg::MODE_PUSH_FRONT, 32'h5A5A_FFFF, 5'd1,  1'b0, NO_VIEW},
        '{deq_pkg::MODE_PUSH_BACK,  32'h7FFF_FFFF, 5'd1,  1'b0, NO_VIEW},
        '{deq_pkg::MODE_REVERSE,    32'h0000_0000, 5'd1,  1'b0, NO_VIEW},
        '{deq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd3,  1'b0, NO_VIEW}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    // deque model state
    logic [31:0] model_slots [QDEPTH];
    logic [3:0]  model_head = '0;
    logic [4:0]  model_fill = '0;
    logic        model_flip = 1'b0;

    deq_view_t   expected_views [$];
    int          fail_count = 0;
    logic        tx_quiet   = 1'b0;
    logic        rx_quiet   = 1'b0;

    double_ended_queue_with_reverse_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic deq_view_t apply_word(input logic [2:0] mode, input logic [31:0] value);
        deq_view_t  view;
        logic       at_low;
        logic [3:0] slot;
        view.status = deq_pkg::ST_OK;
        if (mode == deq_pkg::MODE_PUSH_FRONT || mode == deq_pkg::MODE_PUSH_BACK) begin
            if (model_fill == QDEPTH) begin
                view.status = deq_pkg::ST_FULL;
            end else begin
                at_low = (mode == deq_pkg::MODE_PUSH_FRONT) ^ model_flip;
                if (at_low) begin
                    model_head = model_head - 4'd1;
                    model_slots[model_head] = value;
                end else begin
                    slot = model_head + model_fill[3:0];
                    model_slots[slot] = value;
                end
                model_fill = model_fill + 5'd1;
            end
        end else if (mode <= deq_pkg::MODE_PEEK) begin
            if (model_fill == 0) begin
                view.status = deq_pkg::ST_EMPTY;
            end else if (mode == deq_pkg::MODE_POP_FRONT || mode == deq_pkg::MODE_POP_BACK) begin
                at_low = (mode == deq_pkg::MODE_POP_FRONT) ^ model_flip;
                if (at_low)
                    model_head = model_head + 4'd1;
                model_fill = model_fill - 5'd1;
            end else if (mode == deq_pkg::MODE_REVERSE) begin
                model_flip = !model_flip;
            end
        end
        if (model_fill != 0) begin
            slot = model_head + model_fill[3:0] - 4'd1;
            view.front = model_flip ? model_slots[slot] : model_slots[model_head];
            view.back  = model_flip ? model_slots[model_head] : model_slots[slot];
        end else begin
            view.front = '0;
            view.back  = '0;
        end
        view.empty = (model_fill == 0);
        view.count = model_fill;
        return view;
    endfunction

    // Hold valid across back-to-back words; lower it only when a gap follows.
    task automatic send_word(input logic [2:0] mode, input logic [31:0] value,
                             input logic typed, input deq_view_t want);
        int        gap;
        deq_view_t view;
        if ($urandom_range(0, 31) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        view = apply_word(mode, value);
        expected_views.push_back(typed ? want : view);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    initial begin
        int         lean;
        int         burst;
        int         pick;
        int         sent;
        int         push_pct;
        logic [2:0] mode;
        logic [31:0] value;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[i])
            for (int k = 0; k < SCRIPT[i].reps; k++)
                send_word(SCRIPT[i].mode, SCRIPT[i].value + k, SCRIPT[i].typed,
                          SCRIPT[i].want);

        // bursts lean toward filling, draining or mixing so full and empty recur
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            lean  = $urandom_range(0, 2);
            burst = $urandom_range(8, 40);
            push_pct = (lean == 0) ? 72 : (lean == 1) ? 27 : 47;
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 7))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom;
                endcase
                if (pick < 2) begin
                    mode = pick[0] ? MODE_SPARE7 : MODE_SPARE6;
                end else if (pick < push_pct) begin
                    mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK
                                                : deq_pkg::MODE_PUSH_FRONT;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: mode = deq_pkg::MODE_POP_FRONT;
                        3, 4, 5: mode = deq_pkg::MODE_POP_BACK;
                        6, 7:    mode = deq_pkg::MODE_REVERSE;
                        default: mode = deq_pkg::MODE_PEEK;
                    endcase
                end
                if (mode <= deq_pkg::MODE_PEEK)
                    sent++;
                send_word(mode, value, 1'b0, NO_VIEW);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: lower ready for a random stall, or none in quiet stretches, before taking each word.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        deq_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_views.size() == 0) begin
                $error("result word arrived with nothing expected");
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("front_value", want.front, m_tdata[31:0]);
                check_field("back_value", want.back, m_tdata[63:32]);
                check_field("is_empty", 32'(want.empty), 32'(m_tdata[64]));
                check_field("entry_count", 32'(want.count), 32'(m_tdata[69:65]));
            end
        end
    end

    // Abort when neither side moves a word for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue_with_reverse_core.sv
sim/testbench.sv
